// ===== design/b64d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character lookup for the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int DEFAULT_COUNT_BITS = 16;
   localparam int QUEUE_DEPTH        = 2;
   localparam int QUEUE_PTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR    = 8'h3D;
   localparam logic [1:0] PAD_RUN_MAX = 2'd3;
   localparam logic [1:0] PAD_STRIP_MAX = 2'd2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_OVERRUN   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_SECOND = 2'd1,
      PH_THIRD  = 2'd2,
      PH_FOURTH = 2'd3
   } phase_type;

   // classified beat handed from front to back
   typedef struct packed {
      logic       last;
      logic       pad;
      logic       alpha;
      logic [5:0] sextet;
   } class_type;

   typedef struct packed {
      logic alpha;
      logic [5:0] sextet;
   } lookup_type;

   function automatic lookup_type sextet_of(input logic [7:0] c);
      lookup_type r;
      r.alpha  = 1'b1;
      r.sextet = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.sextet = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.sextet = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.sextet = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.sextet = 6'd62;
      end else if (c == 8'h2F) begin
         r.sextet = 6'd63;
      end else begin
         r.alpha = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== design/b64d_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts character beats and classifies them into pad, alphabet or bad.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_char_code,
   input  logic              req_last_char,
   input  logic              q_full,
   output logic              q_push,
   output b64d_pkg::class_type q_entry
);
   import b64d_pkg::*;

   lookup_type look;

   always_comb begin
      look            = sextet_of(req_char_code);
      q_entry.last    = req_last_char;
      q_entry.pad     = (req_char_code == PAD_CHAR);
      q_entry.alpha   = look.alpha;
      q_entry.sextet  = look.sextet;
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// ===== design/b64d_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue
// Short queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module b64d_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64d_pkg::class_type push_entry,
   input  logic                pop,
   output logic                full,
   output logic                not_empty,
   output b64d_pkg::class_type head
);
   import b64d_pkg::*;

   class_type                 mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] cnt_ff, cnt_in;

   localparam logic [QUEUE_PTR_BITS-1:0] PTR_LAST = QUEUE_PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_CNT_BITS-1:0] CNT_FULL = QUEUE_CNT_BITS'(QUEUE_DEPTH);

   assign full      = (cnt_ff == CNT_FULL);
   assign not_empty = (cnt_ff != '0);
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/b64d_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Quad tracking, byte splice, length count and final status.
// ----------------------------------------------------------------------------
module b64d_back #(
   parameter int COUNT_BITS = b64d_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [COUNT_BITS-1:0] csr_max_bytes,
   input  logic                  q_not_empty,
   input  b64d_pkg::class_type   q_head,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_byte_valid,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_done_res,
   output logic [1:0]            rsp_status,
   output logic [COUNT_BITS-1:0] rsp_byte_count
);
   import b64d_pkg::*;

   localparam int TB = COUNT_BITS + 1;

   logic [COUNT_BITS-1:0] max_ff;
   phase_type             phase_ff, phase_in;
   logic [5:0]            held_ff, held_in;
   logic [1:0]            pad_ff, pad_in;
   logic                  bad_ff, bad_in;
   logic [TB-1:0]         total_ff, total_in;

   logic                  rsp_valid_ff;
   logic                  byte_valid_ff, byte_valid_in;
   logic [7:0]            data_ff, data_in;
   logic                  done_ff;
   status_type            status_ff, status_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic [5:0]    v;
   logic          ok;
   logic [1:0]    strip;
   logic [TB-1:0] fin_tot;
   logic          fin_bad;
   logic [TB-1:0] max_ext;

   assign q_pop   = q_not_empty && (!rsp_valid_ff || !rsp_stall);
   assign max_ext = {1'b0, max_ff};

   always_comb begin
      pad_in        = pad_ff;
      bad_in        = bad_ff;
      v             = '0;
      ok            = 1'b0;
      data_in       = '0;
      byte_valid_in = 1'b0;
      total_in      = total_ff;
      strip         = '0;
      fin_tot       = '0;
      fin_bad       = 1'b0;
      status_in     = ST_OK;
      count_in      = '0;

      if (q_head.pad) begin
         if (pad_ff != PAD_RUN_MAX) begin
            pad_in = pad_ff + 2'd1;
         end
         if (pad_in == PAD_RUN_MAX) begin
            bad_in = 1'b1;
         end
      end else begin
         if (pad_ff != '0) begin
            bad_in = 1'b1;
         end
         pad_in = '0;
         if (!q_head.alpha) begin
            bad_in = 1'b1;
         end else begin
            v  = q_head.sextet;
            ok = 1'b1;
         end
      end

      if (phase_ff != PH_FIRST) begin
         unique case (phase_ff)
            PH_SECOND: data_in = {held_ff, v[5:4]};
            PH_THIRD:  data_in = {held_ff[3:0], v[5:2]};
            default:   data_in = {held_ff[1:0], v};
         endcase
         byte_valid_in = ok && !bad_in && (total_ff < max_ext);
         if (total_ff != '1) begin
            total_in = total_ff + 1'b1;
         end
      end
      if (!byte_valid_in) begin
         data_in = '0;
      end

      phase_in = phase_type'(phase_ff + 2'd1);
      held_in  = v;

      if (q_head.last) begin
         fin_bad = bad_in;
         fin_tot = total_in;
         if (phase_in == PH_FIRST) begin
            strip   = (pad_in > PAD_STRIP_MAX) ? PAD_STRIP_MAX : pad_in;
            fin_tot = (total_in >= TB'(strip)) ? total_in - TB'(strip) : '0;
         end else if (pad_in != '0) begin
            fin_bad = 1'b1;
         end
         if (phase_in == PH_SECOND) begin
            fin_bad = 1'b1;
         end
         if (fin_tot > max_ext) begin
            status_in = ST_OVERRUN;
         end else if (fin_bad) begin
            status_in = ST_MALFORMED;
         end
         count_in = fin_tot[COUNT_BITS] ? '1 : fin_tot[COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= '1;
         phase_ff     <= PH_FIRST;
         held_ff      <= '0;
         pad_ff       <= '0;
         bad_ff       <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            max_ff <= csr_max_bytes;
         end
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
            if (q_head.last) begin
               phase_ff <= PH_FIRST;
               held_ff  <= '0;
               pad_ff   <= '0;
               bad_ff   <= 1'b0;
               total_ff <= '0;
            end else begin
               phase_ff <= phase_in;
               held_ff  <= held_in;
               pad_ff   <= pad_in;
               bad_ff   <= bad_in;
               total_ff <= total_in;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         byte_valid_ff <= byte_valid_in;
         data_ff       <= data_in;
         done_ff       <= q_head.last;
         status_ff     <= status_in;
         count_ff      <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_data_byte  = data_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_status     = status_ff;
   assign rsp_byte_count = count_ff;

`ifndef SYNTHESIS
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_head.last) |=> (phase_ff == PH_FIRST && total_ff == '0 && !bad_ff))
      else $error("string state not cleared after last beat");

   a_byte_needs_phase: assert property (@(posedge clock) disable iff (reset)
      (q_pop && byte_valid_in) |-> (phase_ff != PH_FIRST && !bad_in))
      else $error("byte emitted at first quad position or after error");

   a_quiet_midstring: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !done_ff) |-> (status_ff == ST_OK && count_ff == '0))
      else $error("status or count set on a non-final beat");
`endif

endmodule

// ===== design/base64_stream_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, one character beat in and one result beat out.
// ----------------------------------------------------------------------------
// Takes one character per beat and returns one result beat per character,
// in order. A new character is taken every clock cycle while req_stall is
// low; a result is registered when its beat leaves the queue and updates the
// per-string state (quad position, held sextet, pad run, error flag, length).
// A two-beat queue between the character classifier and that update, plus the
// result register, let two more characters in while a result waits. The
// result for the last character carries the status and the decoded length.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
   parameter int COUNT_BITS = b64d_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [COUNT_BITS-1:0] csr_max_bytes,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_char_code,
   input  logic                  req_last_char,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_byte_valid,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_done_res,
   output logic [1:0]            rsp_status,
   output logic [COUNT_BITS-1:0] rsp_byte_count
);
   import b64d_pkg::*;

   class_type push_entry;
   class_type head;
   logic      push;
   logic      pop;
   logic      full;
   logic      not_empty;

   b64d_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_full        (full),
      .q_push        (push),
      .q_entry       (push_entry)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   b64d_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_max_bytes    (csr_max_bytes),
      .q_not_empty      (not_empty),
      .q_head           (head),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_done_res     (rsp_done_res),
      .rsp_status       (rsp_status),
      .rsp_byte_count   (rsp_byte_count)
   );

endmodule
